@@ sv/nttbm_pkg.sv @@
`default_nettype none
package nttbm_pkg;

  localparam int unsigned CoefW  = 12;
  localparam int unsigned ZetaW  = CoefW + 1;
  localparam int unsigned ProdW  = 2 * CoefW;
  localparam int unsigned RBits  = 16;
  localparam int unsigned LaneW  = RBits + ZetaW;
  localparam int unsigned QModW  = 11;
  localparam int unsigned NStage = 7;
  localparam int unsigned NLane  = 8;

  // Low half of -767 modulo 2^16, used as the Montgomery inverse.
  localparam logic [RBits-1:0] QInvLo = 16'hFD01;
  localparam logic signed [QModW-1:0] QMod = 11'sd769;

  // Stage numbering along the pipeline.
  localparam int unsigned StgProd  = 0;
  localparam int unsigned StgFold0 = 1;
  localparam int unsigned StgFin0  = 2;
  localparam int unsigned StgZeta  = 3;
  localparam int unsigned StgFold1 = 4;
  localparam int unsigned StgFin1  = 5;
  localparam int unsigned StgOut   = 6;

  typedef logic signed [RBits-1:0] res_t;
  typedef logic signed [LaneW-1:0] lane_t;

  typedef struct packed {
    logic [NStage-1:0] ld;
  } flow_t;

endpackage
`default_nettype wire

@@ sv/ntt_pair_basemul_q769_core.sv @@
`default_nettype none
// Channel  Handshake          Payload
// in       valid_i / stall_o  coef_a0_i..coef_a3_i, coef_b0_i..coef_b3_i, twiddle_i
// out      valid_o / stall_i  prod_0_o..prod_3_o
//
// One coefficient group is taken per cycle while stall_o is low; its result is offered on
// valid_o when it reaches the output register.
// The depth is set by the chained reductions: product, two reduction steps, the
// twiddle product, two more reduction steps and the final sums, one register each.
// Reset empties the pipeline; the payload registers are not reset.
// A stall at the output holds each full stage with no empty stage after it, while empty stages still fill.
module ntt_pair_basemul_q769_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     stall_o,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  coef_a0_i,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  coef_a1_i,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  coef_a2_i,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  coef_a3_i,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  coef_b0_i,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  coef_b1_i,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  coef_b2_i,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  coef_b3_i,
  input  wire logic signed [nttbm_pkg::CoefW-1:0]  twiddle_i,
  output logic                                     valid_o,
  input  wire logic                                stall_i,
  output logic signed [nttbm_pkg::CoefW-1:0]       prod_0_o,
  output logic signed [nttbm_pkg::CoefW-1:0]       prod_1_o,
  output logic signed [nttbm_pkg::CoefW-1:0]       prod_2_o,
  output logic signed [nttbm_pkg::CoefW-1:0]       prod_3_o
);

  nttbm_pkg::flow_t flow;

  logic signed [nttbm_pkg::ProdW-1:0] p_d [nttbm_pkg::NLane];
  logic signed [nttbm_pkg::ProdW-1:0] p_q [nttbm_pkg::NLane];
  logic signed [nttbm_pkg::ZetaW-1:0] zp_q [3];
  logic signed [nttbm_pkg::ZetaW-1:0] zn_q [3];
  nttbm_pkg::res_t                    r0 [nttbm_pkg::NLane];
  nttbm_pkg::res_t                    r4_q [nttbm_pkg::NLane];
  nttbm_pkg::res_t                    r5_q [nttbm_pkg::NLane];
  nttbm_pkg::res_t                    r6_q [nttbm_pkg::NLane];
  nttbm_pkg::lane_t                   tz_d [2];
  nttbm_pkg::lane_t                   tz_q [2];
  nttbm_pkg::res_t                    tr [2];
  nttbm_pkg::res_t                    s_d [4];
  logic signed [nttbm_pkg::CoefW-1:0] out_q [4];

  nttbm_flow u_flow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .flow_o  (flow)
  );

  // Lanes per pair: x0*y0, x1*y1, x0*y1, x1*y0.
  assign p_d[0] = coef_a0_i * coef_b0_i;
  assign p_d[1] = coef_a1_i * coef_b1_i;
  assign p_d[2] = coef_a0_i * coef_b1_i;
  assign p_d[3] = coef_a1_i * coef_b0_i;
  assign p_d[4] = coef_a2_i * coef_b2_i;
  assign p_d[5] = coef_a3_i * coef_b3_i;
  assign p_d[6] = coef_a2_i * coef_b3_i;
  assign p_d[7] = coef_a3_i * coef_b2_i;

  always_ff @(posedge clk_i) begin
    if (flow.ld[nttbm_pkg::StgProd]) begin
      p_q     <= p_d;
      zp_q[0] <= nttbm_pkg::ZetaW'(twiddle_i);
      zn_q[0] <= -nttbm_pkg::ZetaW'(twiddle_i);
    end
    if (flow.ld[nttbm_pkg::StgFold0]) begin
      zp_q[1] <= zp_q[0];
      zn_q[1] <= zn_q[0];
    end
    if (flow.ld[nttbm_pkg::StgFin0]) begin
      zp_q[2] <= zp_q[1];
      zn_q[2] <= zn_q[1];
    end
  end

  for (genvar i = 0; i < nttbm_pkg::NLane; i++) begin : g_lane
    nttbm_lane u_lane (
      .clk_i     (clk_i),
      .ld_fold_i (flow.ld[nttbm_pkg::StgFold0]),
      .ld_fin_i  (flow.ld[nttbm_pkg::StgFin0]),
      .v_i       (nttbm_pkg::lane_t'(p_q[i])),
      .r_o       (r0[i])
    );
  end

  // The reduced x1*y1 of each pair is multiplied by the twiddle or its negation.
  assign tz_d[0] = r0[1] * zp_q[2];
  assign tz_d[1] = r0[5] * zn_q[2];

  always_ff @(posedge clk_i) begin
    if (flow.ld[nttbm_pkg::StgZeta]) begin
      tz_q <= tz_d;
      r4_q <= r0;
    end
    if (flow.ld[nttbm_pkg::StgFold1]) begin
      r5_q <= r4_q;
    end
    if (flow.ld[nttbm_pkg::StgFin1]) begin
      r6_q <= r5_q;
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_zlane
    nttbm_lane u_zlane (
      .clk_i     (clk_i),
      .ld_fold_i (flow.ld[nttbm_pkg::StgFold1]),
      .ld_fin_i  (flow.ld[nttbm_pkg::StgFin1]),
      .v_i       (tz_q[j]),
      .r_o       (tr[j])
    );
  end

  // Only the low twelve bits of each sum leave the block.
  assign s_d[0] = tr[0] + r6_q[0];
  assign s_d[1] = r6_q[2] + r6_q[3];
  assign s_d[2] = tr[1] + r6_q[4];
  assign s_d[3] = r6_q[6] + r6_q[7];

  always_ff @(posedge clk_i) begin
    if (flow.ld[nttbm_pkg::StgOut]) begin
      for (int k = 0; k < 4; k++) begin
        out_q[k] <= s_d[k][nttbm_pkg::CoefW-1:0];
      end
    end
  end

  assign prod_0_o = out_q[0];
  assign prod_1_o = out_q[1];
  assign prod_2_o = out_q[2];
  assign prod_3_o = out_q[3];

endmodule
`default_nettype wire

@@ sv/nttbm_flow.sv @@
`default_nettype none
module nttbm_flow (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 stall_o,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output nttbm_pkg::flow_t     flow_o
);

  logic [nttbm_pkg::NStage-1:0] vld_q, vld_d;
  logic [nttbm_pkg::NStage-1:0] rdy;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[nttbm_pkg::NStage-1] = !vld_q[nttbm_pkg::NStage-1] || !stall_i;
    for (int k = nttbm_pkg::NStage - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = valid_i;
    end
    for (int k = 1; k < nttbm_pkg::NStage; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign flow_o.ld = rdy;
  assign stall_o   = !rdy[0];
  assign valid_o   = vld_q[nttbm_pkg::NStage-1];

endmodule
`default_nettype wire

@@ sv/nttbm_lane.sv @@
`default_nettype none
module nttbm_lane (
  input  wire logic              clk_i,
  input  wire logic              ld_fold_i,
  input  wire logic              ld_fin_i,
  input  wire nttbm_pkg::lane_t  v_i,
  output nttbm_pkg::res_t        r_o
);

  logic [nttbm_pkg::RBits-1:0]       m_d, m_q;
  logic signed [nttbm_pkg::ZetaW-1:0] hi_d, hi_q;
  logic [2*nttbm_pkg::RBits-1:0]     mprod;
  logic signed [nttbm_pkg::RBits+nttbm_pkg::QModW-1:0] tprod;
  nttbm_pkg::res_t                   hi_ext, t_ext;
  nttbm_pkg::res_t                   r_d, r_q;

  // First half: the low word times the inverse, kept modulo 2^16.
  assign mprod = v_i[nttbm_pkg::RBits-1:0] * nttbm_pkg::QInvLo;
  assign m_d   = mprod[nttbm_pkg::RBits-1:0];
  assign hi_d  = v_i[nttbm_pkg::LaneW-1:nttbm_pkg::RBits];

  always_ff @(posedge clk_i) begin
    if (ld_fold_i) begin
      m_q  <= m_d;
      hi_q <= hi_d;
    end
  end

  // Second half: floor of m * q / 2^16, subtracted from the high word.
  assign tprod  = $signed(m_q) * nttbm_pkg::QMod;
  assign t_ext  = nttbm_pkg::res_t'(
                    $signed(tprod[nttbm_pkg::RBits+nttbm_pkg::QModW-1:nttbm_pkg::RBits]));
  assign hi_ext = nttbm_pkg::res_t'(hi_q);
  assign r_d    = hi_ext - t_ext;

  always_ff @(posedge clk_i) begin
    if (ld_fin_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule
`default_nettype wire

@@ dv/ntt_pair_basemul_q769_core_test.sv @@
`timescale 1ns / 100ps

module ntt_pair_basemul_q769_core_test;

  localparam int unsigned CW = nttbm_pkg::CoefW;

  localparam longint QInvNeg  = -767;
  localparam longint QModulus = 769;
  localparam int     NumItems = 1350;
  localparam int     Depth    = 7;

  localparam logic [CW-1:0] Zero = 12'h000;
  localparam logic [CW-1:0] Most = 12'h7FF;
  localparam logic [CW-1:0] Least = 12'h800;
  localparam logic [CW-1:0] One  = 12'h001;
  localparam logic [CW-1:0] MOne = 12'hFFF;
  localparam logic [CW-1:0] Odd  = 12'h555;
  localparam logic [CW-1:0] Even = 12'hAAA;

  typedef logic [0:3][CW-1:0] quad_t;

  typedef struct packed {
    quad_t         a;
    quad_t         b;
    logic [CW-1:0] zeta;
  } group_t;

  typedef struct packed {
    logic   known;
    quad_t  prod;
    group_t grp;
  } row_t;

  // Rows with a typed result have a zero operand on one side, so every product is zero.
  localparam row_t CornerRows [15] = '{
    '{1'b1, '{4{Zero}}, '{'{4{Zero}}, '{4{Zero}}, Zero}},
    '{1'b1, '{4{Zero}}, '{'{4{Zero}}, '{4{Most}}, Least}},
    '{1'b1, '{4{Zero}}, '{'{4{Most}}, '{4{Zero}}, Most}},
    '{1'b1, '{4{Zero}}, '{'{4{Least}}, '{4{Zero}}, Least}},
    '{1'b0, '{4{Zero}}, '{'{4{Least}}, '{4{Least}}, Least}},
    '{1'b0, '{4{Zero}}, '{'{4{Most}}, '{4{Most}}, Most}},
    '{1'b0, '{4{Zero}}, '{'{4{Least}}, '{4{Most}}, Least}},
    '{1'b0, '{4{Zero}}, '{'{4{Most}}, '{4{Least}}, Most}},
    '{1'b0, '{4{Zero}}, '{'{Least, Most, Least, Most}, '{Most, Least, Most, Least}, Least}},
    '{1'b0, '{4{Zero}}, '{'{4{One}}, '{4{One}}, One}},
    '{1'b0, '{4{Zero}}, '{'{4{MOne}}, '{4{One}}, MOne}},
    '{1'b0, '{4{Zero}}, '{'{4{Odd}}, '{4{Even}}, Odd}},
    '{1'b0, '{4{Zero}}, '{'{4{Even}}, '{4{Odd}}, Even}},
    '{1'b0, '{4{Zero}}, '{'{Most, Most, Least, Least}, '{Least, Most, Most, Least}, Zero}},
    '{1'b0, '{4{Zero}}, '{'{One, Zero, Zero, One}, '{Zero, One, One, Zero}, Least}}
  };

  logic                 clk;
  logic                 rst_ni;
  logic                 valid_i;
  logic                 stall_o;
  logic signed [CW-1:0] coef_a0_i, coef_a1_i, coef_a2_i, coef_a3_i;
  logic signed [CW-1:0] coef_b0_i, coef_b1_i, coef_b2_i, coef_b3_i;
  logic signed [CW-1:0] twiddle_i;
  logic                 valid_o;
  logic                 stall_i;
  logic signed [CW-1:0] prod_0_o, prod_1_o, prod_2_o, prod_3_o;

  quad_t prods_due [$];
  int    mismatches;

  ntt_pair_basemul_q769_core u_top (
    .clk_i     (clk),
    .rst_ni    (rst_ni),
    .valid_i   (valid_i),
    .stall_o   (stall_o),
    .coef_a0_i (coef_a0_i),
    .coef_a1_i (coef_a1_i),
    .coef_a2_i (coef_a2_i),
    .coef_a3_i (coef_a3_i),
    .coef_b0_i (coef_b0_i),
    .coef_b1_i (coef_b1_i),
    .coef_b2_i (coef_b2_i),
    .coef_b3_i (coef_b3_i),
    .twiddle_i (twiddle_i),
    .valid_o   (valid_o),
    .stall_i   (stall_i),
    .prod_0_o  (prod_0_o),
    .prod_1_o  (prod_1_o),
    .prod_2_o  (prod_2_o),
    .prod_3_o  (prod_3_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("ntt_pair_basemul_q769_core_test failed");
    $finish;
  end

  function automatic longint wrap16(longint v);
    logic signed [15:0] w;
    w = v[15:0];
    return w;
  endfunction

  // Signed Montgomery reduction with R = 2^16, keeping every 16-bit truncation.
  function automatic longint mont_fold(longint v);
    longint hi;
    longint t;
    hi = wrap16(v >>> 16);
    t  = wrap16(wrap16(v) * QInvNeg);
    t  = wrap16((t * QModulus) >>> 16);
    return wrap16(hi - t);
  endfunction

  function automatic quad_t basemul_group(group_t g);
    longint x [0:3];
    longint y [0:3];
    longint z;
    longint s;
    quad_t  r;
    int     k;
    for (k = 0; k < 4; k++) begin
      x[k] = $signed(g.a[k]);
      y[k] = $signed(g.b[k]);
    end
    z = $signed(g.zeta);
    // The second pair uses the negated twiddle, which may reach +2048.
    for (k = 0; k < 2; k++) begin
      s = mont_fold(mont_fold(x[2*k+1] * y[2*k+1]) * (k == 0 ? z : -z)) +
          mont_fold(x[2*k] * y[2*k]);
      r[2*k] = s[CW-1:0];
      s = mont_fold(x[2*k] * y[2*k+1]) + mont_fold(x[2*k+1] * y[2*k]);
      r[2*k+1] = s[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] draw_coef();
    case ($urandom_range(0, 11))
      0: return Least;
      1: return Most;
      2: return Zero;
      3: return CW'($urandom_range(0, 8) - 4);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic group_t draw_group();
    group_t g;
    int     k;
    for (k = 0; k < 4; k++) begin
      g.a[k] = draw_coef();
      g.b[k] = draw_coef();
    end
    g.zeta = draw_coef();
    return g;
  endfunction

  task automatic drive_group(group_t g);
    coef_a0_i = g.a[0];
    coef_a1_i = g.a[1];
    coef_a2_i = g.a[2];
    coef_a3_i = g.a[3];
    coef_b0_i = g.b[0];
    coef_b1_i = g.b[1];
    coef_b2_i = g.b[2];
    coef_b3_i = g.b[3];
    twiddle_i = g.zeta;
  endtask

  // Holds the group until a transfer takes place, then records its result.
  task automatic send_group(group_t g, logic known, quad_t typed);
    @(negedge clk);
    drive_group(g);
    valid_i = 1'b1;
    do @(posedge clk); while (stall_o);
    prods_due.push_back(known ? typed : basemul_group(g));
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      valid_i = 1'b0;
      drive_group(draw_group());
    end
  endtask

  task automatic drain();
    @(negedge clk);
    valid_i = 1'b0;
    while (prods_due.size() != 0) @(posedge clk);
  endtask

  // The receiver switches between stall patterns for random stretches.
  initial begin : stall_pattern
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 4);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: stall_i = 1'b0;
        1: stall_i = ($urandom_range(0, 3) == 0);
        2: stall_i = ($urandom_range(0, 3) != 0);
        3: stall_i = ~stall_i;
        default: stall_i = (left % 16) < 6;
      endcase
    end
  end

  always @(posedge clk) begin : check_prods
    quad_t got;
    quad_t due;
    int    k;
    if (rst_ni && valid_o && !stall_i) begin
      got = {prod_0_o, prod_1_o, prod_2_o, prod_3_o};
      if (prods_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none due, prod_0..3 = %0d %0d %0d %0d", $time,
                 prod_0_o, prod_1_o, prod_2_o, prod_3_o);
      end else begin
        due = prods_due.pop_front();
        for (k = 0; k < 4; k++) begin
          if (got[k] !== due[k]) begin
            mismatches++;
            $display("%0t: prod_%0d expected %0d, got %0d", $time, k,
                     $signed(due[k]), $signed(got[k]));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int     sent;
    int     burst;
    int     k;
    bit     paused;
    mismatches = 0;
    rst_ni     = 1'b0;
    valid_i    = 1'b0;
    stall_i    = 1'b0;
    drive_group('0);
    repeat (Depth) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    for (k = 0; k < 15; k++) begin
      send_group(CornerRows[k].grp, CornerRows[k].known, CornerRows[k].prod);
    end
    drain();

    sent   = 0;
    paused = 1'b0;
    while (sent < NumItems) begin
      burst = $urandom_range(1, 48);
      for (k = 0; k < burst && sent < NumItems; k++) begin
        send_group(draw_group(), 1'b0, '0);
        sent++;
      end
      if (!paused && sent >= NumItems / 2) begin
        drain();
        paused = 1'b1;
      end
      case ($urandom_range(0, 5))
        0, 1: ;
        2: hold_off($urandom_range(5, 15));
        default: hold_off($urandom_range(1, 3));
      endcase
    end

    drain();
    repeat (2 * Depth) @(posedge clk);
    if (mismatches == 0) begin
      $display("ntt_pair_basemul_q769_core_test passed");
    end else begin
      $display("ntt_pair_basemul_q769_core_test failed");
    end
    $finish;
  end

endmodule

@@ ntt_pair_basemul_q769_core.f @@
sv/nttbm_pkg.sv
sv/nttbm_flow.sv
sv/nttbm_lane.sv
sv/ntt_pair_basemul_q769_core.sv
dv/ntt_pair_basemul_q769_core_test.sv
